// ===== sv/gipbc_pkg.sv =====
// Package for the position-keyed GF(2^8) byte cipher.
// Holds shared types, constants and the GF(2^8) multiply; no dependencies.
package gipbc_pkg;

	localparam int COLUMN_BITS = 16;
	localparam int ROW_LEN_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	// register indexes on the configuration channel
	localparam logic [CFG_INDEX_BITS-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_LENGTH = 2'd1;

	// field polynomial without the x^8 term, and the inverse exponent 254
	localparam logic [7:0] GF_POLY_LOW = 8'h1b;
	localparam logic [7:0] INV_EXP = 8'hfe;
	localparam logic [2:0] LAST_STEP = 3'd7;

	typedef struct packed {
		logic                    decrypt;
		logic [ROW_LEN_BITS-1:0] row_length;
	} gipbc_cfg_t;

	// one classified item on its way from front to back
	typedef struct packed {
		logic [7:0] pre_byte;  // byte that enters the inverse
		logic [7:0] off;       // low byte of the column index
		logic       odd;
		logic       decrypt;
	} gipbc_entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DONE
	} gipbc_back_state_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] aa;
		logic       carry;
		acc = 8'h00;
		aa = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ aa;
			end
			carry = aa[7];
			aa = {aa[6:0], 1'b0};
			if (carry) begin
				aa = aa ^ GF_POLY_LOW;
			end
		end
		return acc;
	endfunction

endpackage

// ===== sv/gipbc_if.sv =====
// Valid/ready channel interfaces for the cipher: pixel, result and config.
// Depends on gipbc_pkg for field widths.
interface gipbc_pixel_if;
	import gipbc_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first;
	modport source (output valid, output data_byte, output first, input ready);
	modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface gipbc_result_if;
	import gipbc_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;
	modport source (output valid, output result_byte, input ready);
	modport sink (input valid, input result_byte, output ready);
endinterface

interface gipbc_cfg_if;
	import gipbc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  value;
	modport source (output valid, output index, output value, input ready);
	modport sink (input valid, input index, input value, output ready);
endinterface

// ===== sv/gf_inverse_position_byte_cipher_core.sv =====
// Position-keyed GF(2^8) byte cipher, top level.
// Depends on gipbc_pkg, gipbc_if, gipbc_front, gipbc_queue, gipbc_back.
//
// Usage:
//   pixel  : valid/ready channel with data_byte and first. first clears the
//            column counter before that item. One result per pixel item.
//   result : valid/ready channel with result_byte, in pixel order.
//   cfg    : valid/ready write channel, always ready. Index 0 is mode
//            (0 encrypt, 1 decrypt), index 1 is row_length. Write only
//            while no item is in flight.
//   Encrypt: inverse over x^8+x^4+x^3+x+1, then +column (even) or
//   -column (odd), mod 256. Decrypt: the opposite offset, then inverse.
//   The back end works on one item at a time and takes no new one until it
//   has emitted the last: a load state, eight square-and-multiply steps
//   on one shared pair of GF multipliers, and a done state that hands
//   the byte to the output register.
//   The front end and a two-entry queue keep accepting while the back end
//   works, so up to two items wait behind the one in progress.
//   A stalled receiver holds the output register; the back end then waits
//   with its finished byte and the queue fills before pixel.ready drops.
//   Reset (arst_n low): mode encrypt, row_length 1, column zero, queue
//   and output empty.
module gf_inverse_position_byte_cipher_core (
	input  logic            clk,
	input  logic            arst_n,
	gipbc_pixel_if.sink     pixel,
	gipbc_result_if.source  result,
	gipbc_cfg_if.sink       cfg
);
	import gipbc_pkg::*;

	gipbc_cfg_t   cfg_q;
	logic         push_valid;
	logic         push_ready;
	gipbc_entry_t push_entry;
	logic         pop_valid;
	logic         pop_ready;
	gipbc_entry_t pop_entry;

	// configuration registers; writes to unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decrypt <= 1'b0;
			cfg_q.row_length <= ROW_LEN_BITS'(1);
		end else if (cfg.valid) begin
			if (cfg.index == REG_MODE) begin
				cfg_q.decrypt <= cfg.value[0];
			end else if (cfg.index == REG_ROW_LENGTH) begin
				cfg_q.row_length <= cfg.value[ROW_LEN_BITS-1:0];
			end
		end
	end

	// front: column tracking and decrypt pre-offset
	gipbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// decoupling queue
	gipbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// back: iterative inverse, encrypt post-offset, output register
	gipbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.result    (result)
	);

endmodule

// ===== sv/gipbc_front.sv =====
// Front end: accepts pixel items, tracks the column and applies the
// decrypt pre-offset. Depends on gipbc_pkg and gipbc_if.
module gipbc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	gipbc_pixel_if.sink            pixel,
	input  gipbc_pkg::gipbc_cfg_t  cfg,
	output logic                   push_valid,
	input  logic                   push_ready,
	output gipbc_pkg::gipbc_entry_t push_entry
);
	import gipbc_pkg::*;

	logic [COLUMN_BITS-1:0] column_count_q;
	logic [COLUMN_BITS-1:0] col;
	logic [COLUMN_BITS-1:0] next_col;
	logic [7:0]             off;
	logic                   accept;

	assign pixel.ready = push_ready;
	assign push_valid = pixel.valid;
	assign accept = pixel.valid && push_ready;

	assign col = pixel.first ? '0 : column_count_q;
	assign off = col[7:0];
	assign next_col = col + COLUMN_BITS'(1);

	always_comb begin
		push_entry.off = off;
		push_entry.odd = col[0];
		push_entry.decrypt = cfg.decrypt;
		if (!cfg.decrypt) begin
			push_entry.pre_byte = pixel.data_byte;
		end else if (col[0]) begin
			push_entry.pre_byte = pixel.data_byte + off;
		end else begin
			push_entry.pre_byte = pixel.data_byte - off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
		end else if (accept) begin
			// zero row length also lands here, keeping the column at zero
			if ((COLUMN_BITS + ROW_LEN_BITS)'(cfg.row_length) <=
					(COLUMN_BITS + ROW_LEN_BITS)'(next_col)) begin
				column_count_q <= '0;
			end else begin
				column_count_q <= next_col;
			end
		end
	end

endmodule

// ===== sv/gipbc_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on gipbc_pkg for the entry type.
module gipbc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  gipbc_pkg::gipbc_entry_t push_entry,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output gipbc_pkg::gipbc_entry_t pop_entry
);
	import gipbc_pkg::*;

	gipbc_entry_t mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_entry = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/gipbc_back.sv =====
// Back end: iterative GF(2^8) inverse (x^254 by square and multiply),
// encrypt post-offset and the output register. Depends on gipbc_pkg, gipbc_if.
module gipbc_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pop_valid,
	output logic                    pop_ready,
	input  gipbc_pkg::gipbc_entry_t pop_entry,
	gipbc_result_if.source          result
);
	import gipbc_pkg::*;

	gipbc_back_state_t state_q, state_d;
	logic [7:0] acc_q, base_q, off_q;
	logic       odd_q, decrypt_q;
	logic [2:0] step_q;
	logic [7:0] result_q;
	logic       out_valid_q;

	logic       load;
	logic       step_en;
	logic       emit;
	logic [7:0] final_byte;
	logic [7:0] acc_mul;
	logic [7:0] base_sq;

	assign acc_mul = gf_mul(acc_q, base_q);
	assign base_sq = gf_mul(base_q, base_q);

	always_comb begin
		if (decrypt_q) begin
			final_byte = acc_q;
		end else if (odd_q) begin
			final_byte = acc_q - off_q;
		end else begin
			final_byte = acc_q + off_q;
		end
	end

	always_comb begin
		state_d = state_q;
		load = 1'b0;
		step_en = 1'b0;
		emit = 1'b0;
		pop_ready = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					load = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				step_en = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || result.ready) begin
					emit = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
			end else if (step_en) begin
				step_q <= step_q + 3'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= 8'h01;
			base_q <= pop_entry.pre_byte;
			off_q <= pop_entry.off;
			odd_q <= pop_entry.odd;
			decrypt_q <= pop_entry.decrypt;
		end else if (step_en) begin
			if (INV_EXP[step_q]) begin
				acc_q <= acc_mul;
			end
			base_q <= base_sq;
		end
		if (emit) begin
			result_q <= final_byte;
		end
	end

	assign result.valid = out_valid_q;
	assign result.result_byte = result_q;

endmodule
